### src/json_string_unescape_utf8_top_defines.svh
// Assertion macros used by the checker file of the string unescaper.
`ifndef JSON_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define JSU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jsu check failed");

// Next-cycle implication, disabled while reset is high.
`define JSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jsu check failed");

`endif

### src/jsu_pkg.sv
// Shared types, constants and helpers of the string unescaper.
package jsu_pkg;

   localparam int CP_WIDTH    = 21;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   typedef logic [CP_WIDTH-1:0] cp_type;

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_ESCAPE = 3'd1,
      MODE_HEX4   = 3'd2,
      MODE_HEX3   = 3'd3,
      MODE_HEX2   = 3'd4,
      MODE_HEX1   = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      ST_DATA   = 2'd0,
      ST_DONE   = 2'd1,
      ST_BADHEX = 2'd2,
      ST_EOI    = 2'd3
   } status_type;

   // One classified item handed from front to back.
   typedef struct packed {
      logic       is_status;
      status_type status;
      cp_type     cp;
   } entry_type;

   // Character codes.
   localparam cp_type CP_DQUOTE    = 21'h22;
   localparam cp_type CP_SQUOTE    = 21'h27;
   localparam cp_type CP_BACKSLASH = 21'h5C;
   localparam cp_type CP_LOWER_A   = 21'h61;
   localparam cp_type CP_LOWER_B   = 21'h62;
   localparam cp_type CP_LOWER_F   = 21'h66;
   localparam cp_type CP_LOWER_N   = 21'h6E;
   localparam cp_type CP_LOWER_R   = 21'h72;
   localparam cp_type CP_LOWER_T   = 21'h74;
   localparam cp_type CP_LOWER_U   = 21'h75;
   localparam cp_type CP_BEL       = 21'h07;
   localparam cp_type CP_BS        = 21'h08;
   localparam cp_type CP_TAB       = 21'h09;
   localparam cp_type CP_LF        = 21'h0A;
   localparam cp_type CP_FF        = 21'h0C;
   localparam cp_type CP_CR        = 21'h0D;

   // Hex digit decode: bit 4 marks a valid digit, bits 3:0 hold its value.
   function automatic logic [4:0] hex_digit(input cp_type c);
      logic [4:0] r;
      r = 5'd0;
      if (c inside {[21'h30:21'h39]}) begin
         r = {1'b1, c[3:0]};
      end else if (c inside {[21'h41:21'h46], [21'h61:21'h66]}) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage

### src/jsu_front.sv
// Front end: takes code points, tracks escape state, queues decoded characters.
module jsu_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wen,
   input  logic               csr_wdata,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  jsu_pkg::cp_type    req_code_point,
   input  logic               queue_full,
   output logic               push,
   output jsu_pkg::entry_type push_entry
);
   import jsu_pkg::*;

   mode_type    mode_ff, mode_in;
   logic [15:0] acc_ff, acc_in;
   logic        quote_ff, quote_in;

   logic        accept;
   cp_type      quote_cp;
   cp_type      mapped;
   logic [4:0]  digit;
   logic [15:0] acc_next;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && !queue_full;
   assign quote_cp   = quote_ff ? CP_SQUOTE : CP_DQUOTE;
   assign digit      = hex_digit(req_code_point);
   assign acc_next   = {acc_ff[11:0], digit[3:0]};

   // Map the escaped letter to its control character
   always_comb begin
      case (req_code_point)
         CP_LOWER_A: mapped = CP_BEL;
         CP_LOWER_B: mapped = CP_BS;
         CP_LOWER_F: mapped = CP_FF;
         CP_LOWER_N: mapped = CP_LF;
         CP_LOWER_R: mapped = CP_CR;
         CP_LOWER_T: mapped = CP_TAB;
         default:    mapped = req_code_point;
      endcase
   end

   // Hold the closing quote selection
   assign quote_in = csr_wen ? csr_wdata : quote_ff;

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NORMAL;
         acc_ff   <= 16'd0;
         quote_ff <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         acc_ff   <= acc_in;
         quote_ff <= quote_in;
      end
   end

   // Next escape state and the entry to queue
   always_comb begin
      mode_in    = mode_ff;
      acc_in     = acc_ff;
      push       = 1'b0;
      push_entry = '{is_status: 1'b0, status: ST_DATA, cp: req_code_point};
      if (accept) begin
         case (mode_ff)
            MODE_ESCAPE: begin
               if (req_code_point == CP_LOWER_U) begin
                  mode_in = MODE_HEX4;
                  acc_in  = 16'd0;
               end else begin
                  mode_in       = MODE_NORMAL;
                  push          = 1'b1;
                  push_entry.cp = mapped;
               end
            end
            MODE_HEX4, MODE_HEX3, MODE_HEX2, MODE_HEX1: begin
               if (!digit[4]) begin
                  mode_in              = MODE_NORMAL;
                  acc_in               = 16'd0;
                  push                 = 1'b1;
                  push_entry.is_status = 1'b1;
                  push_entry.status    = ST_BADHEX;
               end else if (mode_ff == MODE_HEX1) begin
                  mode_in       = MODE_NORMAL;
                  acc_in        = 16'd0;
                  push          = 1'b1;
                  push_entry.cp = {{(CP_WIDTH - 16){1'b0}}, acc_next};
               end else begin
                  mode_in = mode_type'(mode_ff + 3'd1);
                  acc_in  = acc_next;
               end
            end
            default: begin
               mode_in = MODE_NORMAL;
               if (req_code_point == quote_cp) begin
                  acc_in               = 16'd0;
                  push                 = 1'b1;
                  push_entry.is_status = 1'b1;
                  push_entry.status    = ST_DONE;
               end else if (req_code_point == CP_BACKSLASH) begin
                  mode_in = MODE_ESCAPE;
               end else begin
                  push = 1'b1;
               end
            end
         endcase
         // A zero character ends the input early
         if (push && !push_entry.is_status && push_entry.cp == '0) begin
            acc_in               = 16'd0;
            push_entry.is_status = 1'b1;
            push_entry.status    = ST_EOI;
         end
      end
   end

endmodule

### src/jsu_queue.sv
// Short register queue between the front end and the byte encoder.
module jsu_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  jsu_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output jsu_pkg::entry_type head_entry
);
   import jsu_pkg::*;

   entry_type               mem_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]   count_ff, count_in;
   logic                    do_pop;

   assign full       = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### src/jsu_back.sv
// Back end: splits queued characters into UTF-8 bytes behind an output register.
module jsu_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  jsu_pkg::entry_type head_entry,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_out_byte,
   output jsu_pkg::status_type rsp_status,
   output logic               rsp_tlast
);
   import jsu_pkg::*;

   logic [1:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   status_type  status_ff, status_in;
   logic        last_ff, last_in;

   logic        load;
   cp_type      cp;
   logic [1:0]  nlast;
   logic [1:0]  remain;
   logic [7:0]  lead;
   logic [5:0]  cont;
   logic [7:0]  data_byte;
   logic        final_byte;

   assign cp   = head_entry.cp;
   assign load = head_valid && (!valid_ff || rsp_tready);

   // Byte count minus one and lead byte of the character
   always_comb begin
      if (cp < 21'h80) begin
         nlast = 2'd0;
         lead  = cp[7:0];
      end else if (cp < 21'h800) begin
         nlast = 2'd1;
         lead  = {3'b110, cp[10:6]};
      end else if (cp < 21'h10000) begin
         nlast = 2'd2;
         lead  = {4'b1110, cp[15:12]};
      end else begin
         nlast = 2'd3;
         lead  = {5'b11110, cp[20:18]};
      end
   end

   // Pick the continuation bits still to send
   assign remain = nlast - idx_ff;
   always_comb begin
      case (remain)
         2'd0:    cont = cp[5:0];
         2'd1:    cont = cp[11:6];
         default: cont = cp[17:12];
      endcase
   end

   assign data_byte  = (idx_ff == 2'd0) ? lead : {2'b10, cont};
   assign final_byte = head_entry.is_status || (remain == 2'd0);
   assign pop        = load && final_byte;

   // Load the next byte into the output register
   always_comb begin
      valid_in  = valid_ff;
      byte_in   = byte_ff;
      status_in = status_ff;
      last_in   = last_ff;
      idx_in    = idx_ff;
      if (load) begin
         valid_in  = 1'b1;
         byte_in   = head_entry.is_status ? 8'd0 : data_byte;
         status_in = head_entry.is_status ? head_entry.status : ST_DATA;
         last_in   = final_byte;
         idx_in    = final_byte ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_tvalid   = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_status   = status_ff;
   assign rsp_tlast    = last_ff;

endmodule

### src/json_string_unescape_utf8_top.sv
// JSON string body unescaper with UTF-8 output: a code point accepted per cycle on req
// while the queue has room, one UTF-8 byte or status word per cycle on rsp while the
// receiver is ready. A multi-byte character stays at the head of the queue until its
// last byte is loaded into the output register, so text that stays in ASCII keeps the
// full rate; the four-entry queue between the escape decoder and the byte encoder
// absorbs short bursts of multi-byte characters and lets either side stall without
// stopping the other. Backslash, u and non-final hex digits produce no word. An accepted
// item is written into the queue and then loaded into the output register for rsp.
module json_string_unescape_utf8_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic        csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [20:0] code_point, [23:21] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [9:8] status, [15:10] zero
   output logic        rsp_tlast    // last_of_run
);
   import jsu_pkg::*;

   logic       queue_full;
   logic       push;
   entry_type  push_entry;
   logic       pop;
   logic       head_valid;
   entry_type  head_entry;
   logic [7:0] out_byte;
   status_type status;

   jsu_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_wen        (csr_wen),
      .csr_wdata      (csr_wdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_code_point (req_tdata[CP_WIDTH-1:0]),
      .queue_full     (queue_full),
      .push           (push),
      .push_entry     (push_entry)
   );

   jsu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   jsu_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_entry   (head_entry),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_out_byte (out_byte),
      .rsp_status   (status),
      .rsp_tlast    (rsp_tlast)
   );

   // Pack the result word
   assign rsp_tdata = {6'd0, status, out_byte};

endmodule

### src/jsu_checker.sv
// Port-level checks on the unescaper result stream, bound to the top level.
`include "json_string_unescape_utf8_top_defines.svh"

module jsu_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A stalled word holds
   `JSU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // Status words carry no byte and close their run
   `JSU_ASSERT_NOW(a_status_word, clock, reset, rsp_tvalid && rsp_tdata[9:8] != 2'd0, rsp_tdata[7:0] == 8'd0 && rsp_tlast)

   // A byte that is not the last of its character is a lead or continuation byte
   `JSU_ASSERT_NOW(a_multibyte, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tdata[9:8] == 2'd0 && (rsp_tdata[7:6] == 2'b11 || rsp_tdata[7:6] == 2'b10))

   // Pad bits stay clear
   `JSU_ASSERT_NOW(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[15:10] == 6'd0)

endmodule

bind json_string_unescape_utf8_top jsu_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
